// ===== hdl/sfd_pkg.sv =====
// Package for the serial frame deframer: frame phases, event and error codes,
// register indexes and reset values. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned NUM_REGS = 7;

	// Fixed frame overhead counted in the length field.
	localparam logic [LEN_W-1:0] HEADER_BYTES = 16'd8;
	localparam logic [BYTE_W-1:0] SEED_RESET  = 8'h73;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_FIRST  = 3'd0,
		REG_START_SECOND = 3'd1,
		REG_OWN_ID       = 3'd2,
		REG_CMD_INFO     = 3'd3,
		REG_CMD_CONTROL  = 3'd4,
		REG_END_BYTE     = 3'd5,
		REG_SEED         = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_GOOD    = 2'd2,
		EV_ERROR   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_START1   = 3'd1,
		ERR_START2   = 3'd2,
		ERR_TARGET   = 3'd3,
		ERR_CHECKSUM = 3'd4,
		ERR_END      = 3'd5,
		ERR_COMMAND  = 3'd6
	} err_t;

	typedef enum logic [10:0] {
		PH_START1  = 11'b000_0000_0001,
		PH_START2  = 11'b000_0000_0010,
		PH_TARGET  = 11'b000_0000_0100,
		PH_SOURCE  = 11'b000_0000_1000,
		PH_LEN_HI  = 11'b000_0001_0000,
		PH_LEN_LO  = 11'b000_0010_0000,
		PH_COMMAND = 11'b000_0100_0000,
		PH_PAYLOAD = 11'b000_1000_0000,
		PH_CHECK   = 11'b001_0000_0000,
		PH_END     = 11'b010_0000_0000,
		PH_BADCMD  = 11'b100_0000_0000
	} phase_t;

endpackage

`default_nettype wire

// ===== hdl/serial_frame_deframer_unit.sv =====
// Top level of the serial frame deframer: input register, frame parser and
// result register in one module. Depends on sfd_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | into      | in_valid / in_stall  | rx_byte
//  out     | out of    | out_valid / out_stall| event_kind, payload_byte,
//          |           |                      | payload_index, command_kind,
//          |           |                      | source_node, error_kind
//  cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every accepted byte gives exactly one result item: it is held in the input
// register, then passes through the parser into the result register.
// One byte per cycle is sustained while the output does not stall; the frame
// state registers close their loops through combinational logic only.
// Reset clears the phase, the running sum and the frame fields, and returns the
// settings to their reset values, with the checksum seed at 0x73.
// A stall on the output holds the result register and a full input register;
// in_stall is raised only while the input register is full and cannot drain.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_unit
	import sfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic [BYTE_W-1:0]    rx_byte,

	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [1:0]           event_kind,
	output      logic [BYTE_W-1:0]    payload_byte,
	output      logic [LEN_W-1:0]     payload_index,
	output      logic                 command_kind,
	output      logic [BYTE_W-1:0]    source_node,
	output      logic [2:0]           error_kind,

	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [BYTE_W-1:0] start_first_q, start_second_q, own_id_q;
	logic [BYTE_W-1:0] cmd_info_q, cmd_control_q, end_byte_q, seed_q;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Frame state.
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [LEN_W-1:0]  length_q, length_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0] sender_q, sender_d;
	logic              command_q, command_d;

	// Result register.
	logic              out_valid_q;
	event_t            event_q, event_d;
	logic [BYTE_W-1:0] pbyte_q, pbyte_d;
	logic [LEN_W-1:0]  pindex_q, pindex_d;
	logic              ckind_q, ckind_d;
	logic [BYTE_W-1:0] source_q, source_d;
	err_t              err_q, err_d;

	logic              out_free, advance;
	logic [LEN_W-1:0]  count_inc, length_less;
	logic              last_payload;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= '0;
			start_second_q <= '0;
			own_id_q       <= '0;
			cmd_info_q     <= '0;
			cmd_control_q  <= '0;
			end_byte_q     <= '0;
			seed_q         <= SEED_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_FIRST:  start_first_q  <= cfg_data;
				REG_START_SECOND: start_second_q <= cfg_data;
				REG_OWN_ID:       own_id_q       <= cfg_data;
				REG_CMD_INFO:     cmd_info_q     <= cfg_data;
				REG_CMD_CONTROL:  cmd_control_q  <= cfg_data;
				REG_END_BYTE:     end_byte_q     <= cfg_data;
				REG_SEED:         seed_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign count_inc   = count_q + 16'd1;
	assign length_less = length_q - HEADER_BYTES;
	// The payload ends once the count reaches length minus eight; shorter
	// lengths still carry one byte.
	assign last_payload = (length_q < HEADER_BYTES) || (length_less <= count_inc);

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		length_d  = length_q;
		count_d   = count_q;
		sender_d  = sender_q;
		command_d = command_q;
		event_d   = EV_NONE;
		pbyte_d   = '0;
		pindex_d  = '0;
		err_d     = ERR_NONE;

		case (phase_q)
			PH_START1: begin
				if (byte_s1 == start_first_q) phase_d = PH_START2;
				else err_d = ERR_START1;
			end
			PH_START2: begin
				if (byte_s1 == start_second_q) phase_d = PH_TARGET;
				else err_d = ERR_START2;
			end
			PH_TARGET: begin
				if (byte_s1 == own_id_q) phase_d = PH_SOURCE;
				else err_d = ERR_TARGET;
			end
			PH_SOURCE: begin
				sender_d = byte_s1;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {byte_s1, 8'h00};
				sum_d    = seed_q + own_id_q + sender_q + byte_s1;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {length_q[LEN_W-1:BYTE_W], byte_s1};
				sum_d    = sum_q + byte_s1;
				phase_d  = PH_COMMAND;
			end
			PH_COMMAND: begin
				sum_d   = sum_q + byte_s1;
				count_d = '0;
				if (byte_s1 == cmd_info_q) begin
					command_d = 1'b0;
					phase_d   = PH_PAYLOAD;
				end else if (byte_s1 == cmd_control_q) begin
					command_d = 1'b1;
					phase_d   = PH_PAYLOAD;
				end else begin
					phase_d = PH_BADCMD;
				end
			end
			PH_PAYLOAD: begin
				sum_d    = sum_q + byte_s1;
				count_d  = count_inc;
				event_d  = EV_PAYLOAD;
				pbyte_d  = byte_s1;
				pindex_d = count_q;
				if (last_payload) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				if (byte_s1 == sum_q) phase_d = PH_END;
				else err_d = ERR_CHECKSUM;
			end
			PH_END: begin
				if (byte_s1 == end_byte_q) begin
					phase_d  = PH_START1;
					event_d  = EV_GOOD;
					pindex_d = count_q;
				end else begin
					err_d = ERR_END;
				end
			end
			default: begin
				err_d = ERR_COMMAND;
			end
		endcase

		if (err_d != ERR_NONE) begin
			phase_d = PH_START1;
			event_d = EV_ERROR;
		end

		// Frame fields are shown only with payload and frame-good items.
		if (event_d == EV_PAYLOAD || event_d == EV_GOOD) begin
			ckind_d  = command_d;
			source_d = sender_d;
		end else begin
			ckind_d  = 1'b0;
			source_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START1;
			sum_q     <= '0;
			length_q  <= '0;
			count_q   <= '0;
			sender_q  <= '0;
			command_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			length_q  <= length_d;
			count_q   <= count_d;
			sender_q  <= sender_d;
			command_q <= command_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q  <= event_d;
			pbyte_q  <= pbyte_d;
			pindex_q <= pindex_d;
			ckind_q  <= ckind_d;
			source_q <= source_d;
			err_q    <= err_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = event_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pindex_q;
	assign command_kind  = ckind_q;
	assign source_node   = source_q;
	assign error_kind    = err_q;

endmodule

`default_nettype wire
